// File: sv/sphk_pkg.sv
// shared constants, types and the stage records for the sph cubic spline kernel
package sphk_pkg;

   localparam int FracBits  = 16;
   localparam int InWidth   = 24;
   localparam int OutWidth  = 32;
   localparam int StWidth   = 2;

   // u = (r << F) / h, at most 2*2^F after region screen, so it fits in F+2 bits
   localparam int QuoBits   = InWidth + FracBits;
   localparam int DivSteps  = QuoBits;
   localparam int ShapeBits = FracBits + 3;
   localparam int NumShift  = 3 * FracBits + 28;
   localparam int NumBits   = ShapeBits + NumShift;
   localparam int DenBits   = 3 * InWidth + 32;
   localparam int KDivSteps = NumBits;

   localparam logic [31:0] PiQ30 = 32'd3373259426;

   localparam logic [StWidth-1:0] StOk    = 2'd0;
   localparam logic [StWidth-1:0] StSat   = 2'd1;
   localparam logic [StWidth-1:0] StZeroH = 2'd2;

   typedef struct packed {
      logic                valid;
      logic                zero_h;
      logic                beyond;
      logic                inner;
   } flags_type;

   // record carried through the first divide chain
   typedef struct packed {
      flags_type            fl;
      logic [InWidth-1:0]   h;
      logic [QuoBits-1:0]   num;
      logic [InWidth:0]     rem;
      logic [QuoBits-1:0]   quo;
   } ucell_type;

   // record carried through the kernel divide chain
   typedef struct packed {
      flags_type            fl;
      logic [DenBits-1:0]   den;
      logic [NumBits-1:0]   num;
      logic [DenBits:0]     rem;
      logic [NumBits-1:0]   quo;
   } kcell_type;

endpackage

// File: sv/sphk_ucell.sv
// one restoring step of u = (r << F) / h
module sphk_ucell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  sphk_pkg::ucell_type  cell_i,
   output sphk_pkg::ucell_type  cell_o
);
   sphk_pkg::ucell_type cell_ff, cell_in;
   logic [sphk_pkg::InWidth+1:0] trial;
   logic [sphk_pkg::InWidth+1:0] shifted;

   always_comb begin
      cell_in = cell_i;
      shifted = {cell_i.rem, cell_i.num[sphk_pkg::QuoBits-1]};
      trial   = shifted - {2'b00, cell_i.h};
      cell_in.num = {cell_i.num[sphk_pkg::QuoBits-2:0], 1'b0};
      if (!trial[sphk_pkg::InWidth+1]) begin
         cell_in.rem = trial[sphk_pkg::InWidth:0];
         cell_in.quo = {cell_i.quo[sphk_pkg::QuoBits-2:0], 1'b1};
      end else begin
         cell_in.rem = shifted[sphk_pkg::InWidth:0];
         cell_in.quo = {cell_i.quo[sphk_pkg::QuoBits-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.fl.valid <= 1'b0;
      end else if (advance) begin
         cell_ff.fl.valid <= cell_in.fl.valid;
      end
      if (advance) begin
         cell_ff.fl.zero_h <= cell_in.fl.zero_h;
         cell_ff.fl.beyond <= cell_in.fl.beyond;
         cell_ff.fl.inner  <= cell_in.fl.inner;
         cell_ff.h   <= cell_in.h;
         cell_ff.num <= cell_in.num;
         cell_ff.rem <= cell_in.rem;
         cell_ff.quo <= cell_in.quo;
      end
   end

   assign cell_o = cell_ff;
endmodule

// File: sv/sphk_kcell.sv
// one restoring step of the final kernel divide
module sphk_kcell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  sphk_pkg::kcell_type  cell_i,
   output sphk_pkg::kcell_type  cell_o
);
   sphk_pkg::kcell_type cell_ff, cell_in;
   logic [sphk_pkg::DenBits+1:0] trial;
   logic [sphk_pkg::DenBits+1:0] shifted;

   always_comb begin
      cell_in = cell_i;
      shifted = {cell_i.rem, cell_i.num[sphk_pkg::NumBits-1]};
      trial   = shifted - {2'b00, cell_i.den};
      cell_in.num = {cell_i.num[sphk_pkg::NumBits-2:0], 1'b0};
      if (!trial[sphk_pkg::DenBits+1]) begin
         cell_in.rem = trial[sphk_pkg::DenBits:0];
         cell_in.quo = {cell_i.quo[sphk_pkg::NumBits-2:0], 1'b1};
      end else begin
         cell_in.rem = shifted[sphk_pkg::DenBits:0];
         cell_in.quo = {cell_i.quo[sphk_pkg::NumBits-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.fl.valid <= 1'b0;
      end else if (advance) begin
         cell_ff.fl.valid <= cell_in.fl.valid;
      end
      if (advance) begin
         cell_ff.fl.zero_h <= cell_in.fl.zero_h;
         cell_ff.fl.beyond <= cell_in.fl.beyond;
         cell_ff.fl.inner  <= cell_in.fl.inner;
         cell_ff.den <= cell_in.den;
         cell_ff.num <= cell_in.num;
         cell_ff.rem <= cell_in.rem;
         cell_ff.quo <= cell_in.quo;
      end
   end

   assign cell_o = cell_ff;
endmodule

// File: sv/sphk_shape.sv
// shape polynomial and pi*h^3, multipliers split over registered stages
module sphk_shape (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  sphk_pkg::ucell_type  u_i,
   output sphk_pkg::kcell_type  k_o
);
   localparam int F  = sphk_pkg::FracBits;
   localparam int W  = sphk_pkg::InWidth;
   localparam int VB = F + 2;
   localparam int DB = sphk_pkg::DenBits;

   // stage a: pick base value v (u or 2-u)
   sphk_pkg::flags_type         fa_ff;
   logic [VB-1:0]               va_ff;
   logic [W-1:0]                ha_ff;
   // stage b: square v, h^2
   sphk_pkg::flags_type         fb_ff;
   logic [VB-1:0]               vb_ff;
   logic [2*W-1:0]              h2b_ff;
   logic [W-1:0]                hb_ff;
   // stage c: v^2 truncated, h^3 as two partial products
   sphk_pkg::flags_type         fc_ff;
   logic [VB-1:0]               vc_ff;
   logic [2*VB-F-1:0]           v2c_ff;
   logic [2*W-1:0]              h3lo_c_ff;
   logic [2*W-1:0]              h3hi_c_ff;
   // stage d: shape, h^3
   sphk_pkg::flags_type         fd_ff;
   logic [sphk_pkg::ShapeBits-1:0] sd_ff;
   logic [3*W-1:0]              h3d_ff;
   // stage e: shape, pi*h^3 as three partial products
   sphk_pkg::flags_type         fe_ff;
   logic [sphk_pkg::ShapeBits-1:0] se_ff;
   logic [W+31:0]               pe0_ff;
   logic [W+31:0]               pe1_ff;
   logic [W+31:0]               pe2_ff;
   // stage o: shape and pi*h^3
   sphk_pkg::flags_type         fo_ff;
   logic [sphk_pkg::ShapeBits-1:0] so_ff;
   logic [DB-1:0]               dno_ff;

   logic [VB-1:0]               v_in;
   logic [2*VB-1:0]             vsq;
   logic [2*VB-F-1:0]           v2_in;
   logic [3*VB-F-1:0]           vcu;
   logic [3*VB-2*F-1:0]         v3;
   logic [sphk_pkg::ShapeBits+2:0] pos, neg;
   logic [sphk_pkg::ShapeBits-1:0] s_in;
   logic [3*W-1:0]              h3_in;
   logic [DB-1:0]               den_in;

   always_comb begin
      if (u_i.fl.inner) begin
         v_in = u_i.quo[VB-1:0];
      end else begin
         v_in = VB'(2 << F) - u_i.quo[VB-1:0];
      end
      vsq   = vb_ff * vb_ff;
      v2_in = vsq[2*VB-1:F];
      // cube from v^2 and v of the same item, both held in stage c
      vcu   = v2c_ff * vc_ff;
      v3    = vcu[3*VB-F-1:F];
      pos = (sphk_pkg::ShapeBits+3)'(4 << F) + (sphk_pkg::ShapeBits+3)'(3 * v3);
      neg = (sphk_pkg::ShapeBits+3)'(6 * v2c_ff);
      if (fc_ff.inner) begin
         s_in = (pos >= neg) ? sphk_pkg::ShapeBits'(pos - neg) : '0;
      end else begin
         s_in = sphk_pkg::ShapeBits'(v3);
      end
      h3_in  = {h3hi_c_ff, W'(0)} + (3*W)'(h3lo_c_ff);
      den_in = DB'(pe0_ff) + (DB'(pe1_ff) << W) + (DB'(pe2_ff) << (2*W));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fa_ff.valid <= 1'b0;
         fb_ff.valid <= 1'b0;
         fc_ff.valid <= 1'b0;
         fd_ff.valid <= 1'b0;
         fe_ff.valid <= 1'b0;
         fo_ff.valid <= 1'b0;
      end else if (advance) begin
         fa_ff.valid <= u_i.fl.valid;
         fb_ff.valid <= fa_ff.valid;
         fc_ff.valid <= fb_ff.valid;
         fd_ff.valid <= fc_ff.valid;
         fe_ff.valid <= fd_ff.valid;
         fo_ff.valid <= fe_ff.valid;
      end
      if (advance) begin
         fa_ff.zero_h <= u_i.fl.zero_h;
         fa_ff.beyond <= u_i.fl.beyond;
         fa_ff.inner  <= u_i.fl.inner;
         va_ff  <= v_in;
         ha_ff  <= u_i.h;
         fb_ff.zero_h <= fa_ff.zero_h;
         fb_ff.beyond <= fa_ff.beyond;
         fb_ff.inner  <= fa_ff.inner;
         vb_ff  <= va_ff;
         h2b_ff <= ha_ff * ha_ff;
         hb_ff  <= ha_ff;
         fc_ff.zero_h <= fb_ff.zero_h;
         fc_ff.beyond <= fb_ff.beyond;
         fc_ff.inner  <= fb_ff.inner;
         vc_ff  <= vb_ff;
         v2c_ff <= v2_in;
         h3lo_c_ff <= h2b_ff[W-1:0] * hb_ff;
         h3hi_c_ff <= h2b_ff[2*W-1:W] * hb_ff;
         fd_ff.zero_h <= fc_ff.zero_h;
         fd_ff.beyond <= fc_ff.beyond;
         fd_ff.inner  <= fc_ff.inner;
         sd_ff  <= s_in;
         h3d_ff <= h3_in;
         fe_ff.zero_h <= fd_ff.zero_h;
         fe_ff.beyond <= fd_ff.beyond;
         fe_ff.inner  <= fd_ff.inner;
         se_ff  <= sd_ff;
         pe0_ff <= h3d_ff[W-1:0] * sphk_pkg::PiQ30;
         pe1_ff <= h3d_ff[2*W-1:W] * sphk_pkg::PiQ30;
         pe2_ff <= h3d_ff[3*W-1:2*W] * sphk_pkg::PiQ30;
         fo_ff.zero_h <= fe_ff.zero_h;
         fo_ff.beyond <= fe_ff.beyond;
         fo_ff.inner  <= fe_ff.inner;
         so_ff  <= se_ff;
         dno_ff <= den_in;
      end
   end

   sphk_pkg::kcell_type k_out;
   always_comb begin
      k_out        = '0;
      k_out.fl     = fo_ff;
      k_out.den    = dno_ff;
      k_out.num    = sphk_pkg::NumBits'(so_ff) << sphk_pkg::NumShift;
      k_out.rem    = '0;
      k_out.quo    = '0;
   end
   assign k_o = k_out;
endmodule

// File: sv/sph_cubic_spline_kernel_top.sv
// sph cubic spline kernel top: divide chain, shape stages, kernel divide chain
// channel | dir | tdata fields (low bit first)
// req     | in  | pair_distance[23:0], smoothing_length[47:24]
// rsp     | out | kernel_value[31:0], status[33:32] (zero fill to 40 bits)
// one item accepted per cycle while rsp is not stalled
// most of the latency is in the two restoring divide chains, one quotient bit per cell
// reset clears every valid bit; payload registers are not reset
// a stalled rsp freezes the whole chain, the output stage holds its item
module sph_cubic_spline_kernel_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pair_distance, smoothing_length
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // kernel_value, status
);
   localparam int W  = sphk_pkg::InWidth;
   localparam int F  = sphk_pkg::FracBits;
   localparam int UN = sphk_pkg::DivSteps;
   localparam int KN = sphk_pkg::KDivSteps;

   logic advance;
   logic [W-1:0] r_w, h_w;
   assign r_w = req_tdata[W-1:0];
   assign h_w = req_tdata[2*W-1:W];

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   sphk_pkg::ucell_type uc [0:UN];
   sphk_pkg::kcell_type kc [0:KN];

   always_comb begin
      uc[0]           = '0;
      uc[0].fl.valid  = req_tvalid;
      uc[0].fl.zero_h = (h_w == '0);
      uc[0].fl.beyond = ({1'b0, r_w} > {h_w, 1'b0});
      uc[0].fl.inner  = (r_w <= h_w);
      uc[0].h         = h_w;
      uc[0].num       = {r_w, F'(0)};
   end

   genvar g;
   generate
      for (g = 0; g < UN; g++) begin : g_u
         sphk_ucell u_cell (.clock(clock), .reset(reset), .advance(advance),
                            .cell_i(uc[g]), .cell_o(uc[g+1]));
      end
   endgenerate

   sphk_shape shape (.clock(clock), .reset(reset), .advance(advance),
                     .u_i(uc[UN]), .k_o(kc[0]));

   generate
      for (g = 0; g < KN; g++) begin : g_k
         sphk_kcell k_cell (.clock(clock), .reset(reset), .advance(advance),
                            .cell_i(kc[g]), .cell_o(kc[g+1]));
      end
   endgenerate

   logic                          rsp_valid_ff;
   logic [sphk_pkg::OutWidth-1:0] kv_ff, kv_in;
   logic [sphk_pkg::StWidth-1:0]  st_ff, st_in;

   always_comb begin
      if (kc[KN].fl.zero_h) begin
         kv_in = '0;
         st_in = sphk_pkg::StZeroH;
      end else if (kc[KN].fl.beyond) begin
         kv_in = '0;
         st_in = sphk_pkg::StOk;
      end else if (|kc[KN].quo[sphk_pkg::NumBits-1:sphk_pkg::OutWidth]) begin
         kv_in = '1;
         st_in = sphk_pkg::StSat;
      end else begin
         kv_in = kc[KN].quo[sphk_pkg::OutWidth-1:0];
         st_in = sphk_pkg::StOk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= kc[KN].fl.valid;
      end
      if (advance) begin
         kv_ff <= kv_in;
         st_ff <= st_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, st_ff, kv_ff};
endmodule

// File: sv/sphk_checker.sv
// port checker for the sph kernel top, bound to it
module sphk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] <= sphk_pkg::StZeroH)
      else $error("bad status code");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] == sphk_pkg::StSat |-> rsp_tdata[31:0] == 32'hFFFFFFFF)
      else $error("saturated value wrong");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
endmodule

bind sph_cubic_spline_kernel_top sphk_checker u_chk (.*);

// File: dv/sph_cubic_spline_kernel_top_tb.sv
// self-checking testbench for the sph cubic spline kernel top
`timescale 1ns / 100ps

module sph_cubic_spline_kernel_top_tb;

   localparam int RandItems  = 1100;
   localparam int CycleLimit = 400000;
   localparam int DrainWait  = 400;
   localparam int HoldCycles = 600;
   localparam int NumRows    = 22;

   typedef struct packed {
      logic [sphk_pkg::OutWidth-1:0] kernel;
      logic [sphk_pkg::StWidth-1:0]  status;
   } kernel_res_type;

   typedef struct {
      logic [sphk_pkg::InWidth-1:0]  r;
      logic [sphk_pkg::InWidth-1:0]  h;
      logic                          typed;
      kernel_res_type                res;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // pair_distance, smoothing_length
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // kernel_value, status

   kernel_res_type kernel_queue[$];
   int   errors;
   int   cycles;
   int   rx_stall_pct;
   int   tx_idle_pct;
   bit   rx_hold;

   sph_cubic_spline_kernel_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic kernel_res_type cubic_spline_weight(
         logic [sphk_pkg::InWidth-1:0] r, logic [sphk_pkg::InWidth-1:0] h);
      kernel_res_type res;
      logic [63:0]  u, u2, u3, pos, neg, d, d2, s;
      logic [127:0] num, den, q;
      res.kernel = '0;
      res.status = sphk_pkg::StOk;
      if (h == 0) begin
         res.status = sphk_pkg::StZeroH;
      end else if ({40'd0, r} > 64'd2 * h) begin
         res.status = sphk_pkg::StOk;
      end else begin
         u = ({40'd0, r} << sphk_pkg::FracBits) / h;
         if (r <= h) begin
            u2  = (u * u) >> sphk_pkg::FracBits;
            u3  = (u2 * u) >> sphk_pkg::FracBits;
            pos = (64'd4 << sphk_pkg::FracBits) + 64'd3 * u3;
            neg = 64'd6 * u2;
            s   = (pos >= neg) ? pos - neg : 64'd0;
         end else begin
            d  = (64'd2 << sphk_pkg::FracBits) - u;
            d2 = (d * d) >> sphk_pkg::FracBits;
            s  = (d2 * d) >> sphk_pkg::FracBits;
         end
         den = 128'(h) * 128'(h) * 128'(h) * 128'(sphk_pkg::PiQ30);
         num = 128'(s) << sphk_pkg::NumShift;
         q   = num / den;
         if (q > 128'hFFFF_FFFF) begin
            res.kernel = '1;
            res.status = sphk_pkg::StSat;
         end else begin
            res.kernel = q[31:0];
         end
      end
      return res;
   endfunction

   task automatic send_pair(logic [sphk_pkg::InWidth-1:0] r,
                            logic [sphk_pkg::InWidth-1:0] h,
                            bit typed, kernel_res_type typed_res);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {h, r};
      do @(posedge clock); while (!req_tready);
      kernel_queue.insert(kernel_queue.size(), typed ? typed_res : cubic_spline_weight(r, h));
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_queue();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (kernel_queue.size() != 0) @(posedge clock);
   endtask

   // receiver: check the oldest expectation on each rsp transfer
   initial begin
      kernel_res_type want;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (kernel_queue.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time,
                        rsp_tdata[33:0]);
               errors++;
            end else begin
               want = kernel_queue.pop_front();
               if (rsp_tdata[31:0] !== want.kernel) begin
                  $display("%0t: kernel_value expected %h actual %h", $time,
                           want.kernel, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[33:32] !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_tdata[33:32]);
                  errors++;
               end
            end
         end
         if (rx_hold) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            rx_hold = 1'b0;
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type rows [0:NumRows-1];
      kernel_res_type none, zero_ok, zero_h, sat;
      logic [sphk_pkg::InWidth-1:0] r, h;
      int shift, k;
      none    = '0;
      zero_ok = '{kernel: '0, status: sphk_pkg::StOk};
      zero_h  = '{kernel: '0, status: sphk_pkg::StZeroH};
      sat     = '{kernel: '1, status: sphk_pkg::StSat};
      errors = 0;
      rx_stall_pct = 0;
      tx_idle_pct = 0;
      rx_hold = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows[0]  = '{24'd0,       24'd0,       1, zero_h};
      rows[1]  = '{24'hFFFFFF,  24'd0,       1, zero_h};
      rows[2]  = '{24'd0,       24'd1,       1, sat};
      rows[3]  = '{24'd1,       24'd1,       1, sat};
      rows[4]  = '{24'd3,       24'd1,       1, zero_ok};
      rows[5]  = '{24'hFFFFFF,  24'd1,       1, zero_ok};
      rows[6]  = '{24'hFFFFFF,  24'h7FFFFF,  1, zero_ok};
      rows[7]  = '{24'hFFFFFE,  24'h7FFFFF,  0, none};
      rows[8]  = '{24'd0,       24'hFFFFFF,  0, none};
      rows[9]  = '{24'hFFFFFF,  24'hFFFFFF,  0, none};
      rows[10] = '{24'h010000,  24'h010000,  0, none};
      rows[11] = '{24'h020000,  24'h010000,  0, none};
      rows[12] = '{24'h020001,  24'h010000,  1, zero_ok};
      rows[13] = '{24'h008000,  24'h010000,  0, none};
      rows[14] = '{24'h018000,  24'h010000,  0, none};
      rows[15] = '{24'd0,       24'h010000,  0, none};
      rows[16] = '{24'h00FFFF,  24'h010000,  0, none};
      rows[17] = '{24'h010001,  24'h010000,  0, none};
      rows[18] = '{24'd0,       24'h000100,  0, none};
      rows[19] = '{24'h001000,  24'h000800,  0, none};
      rows[20] = '{24'h1FFFFF,  24'h100000,  0, none};
      rows[21] = '{24'd0,       24'h0001FF,  0, none};
      foreach (rows[i]) send_pair(rows[i].r, rows[i].h, rows[i].typed, rows[i].res);
      drain_queue();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
            default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
         endcase
         // long receiver hold-off so the chain fills and stalls req
         if (phase == 0) rx_hold = 1'b1;
         for (k = 0; k < RandItems / 4; k++) begin
            if ($urandom_range(9) == 0) begin
               r = 24'($urandom);
               h = 24'($urandom);
               if ($urandom_range(19) == 0) h = '0;
            end else begin
               shift = $urandom_range(0, 22);
               h = 24'($urandom) >> shift;
               if (h == 0) h = 24'd1;
               r = 24'((longint'(h) * $urandom_range(0, 2300)) / 1000);
               if ($urandom_range(7) == 0) r = 24'(2 * longint'(h) + $urandom_range(0, 2));
            end
            send_pair(r, h, 0, none);
         end
         // sender waits for every outstanding result
         drain_queue();
      end

      repeat (DrainWait) @(posedge clock);
      if (errors == 0 && kernel_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (kernel_queue.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, kernel_queue.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
